// File: rtl/afdt_pkg.sv
// Shared types and constants for the ADC frame to decimal text formatter.
// Used by afdt_front, afdt_queue, afdt_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package afdt_pkg;

  localparam int NUM_CH = 8;
  localparam int CH_W   = 3;

  typedef logic [15:0] sample_t;
  typedef sample_t [NUM_CH-1:0] frame_t;

  typedef struct packed {
    logic [6:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } chan_t;

  typedef chan_t [NUM_CH-1:0] line_t;

  localparam logic [12:0] SCALE_MUL  = 13'd5560;
  localparam logic [15:0] SCALE_DIV  = 16'd32767;
  localparam logic [15:0] OFFSET     = 16'd3276;
  localparam logic [14:0] RECIP_1000 = 15'd16777;
  localparam logic [9:0]  K_1000     = 10'd1000;
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam logic [6:0]  K_100      = 7'd100;
  localparam logic [7:0]  RECIP_10   = 8'd205;
  localparam logic [3:0]  K_10       = 4'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_CR    = 8'h0d;
  localparam logic [7:0] ASCII_LF    = 8'h0a;

  localparam logic [CH_W-1:0] LAST_CH = 3'd7;

  localparam logic [2:0] SUB_THOU  = 3'd0;
  localparam logic [2:0] SUB_HUND  = 3'd1;
  localparam logic [2:0] SUB_TENS  = 3'd2;
  localparam logic [2:0] SUB_UNITS = 3'd3;
  localparam logic [2:0] SUB_SEP   = 3'd4;
  localparam logic [2:0] SUB_LF    = 3'd5;

endpackage

`default_nettype wire

// File: rtl/afdt_front.sv
// Front part: accepts a frame and converts its eight samples to decimal digits.
// One channel enters the scale and digit pipeline per cycle. Uses afdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afdt_front import afdt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire frame_t frame_in,
  output logic        push_valid,
  input  wire logic   push_ready,
  output line_t       push_data
);

  logic            busy;
  logic            issuing;
  logic [CH_W-1:0] issue_idx;
  frame_t          frame;
  line_t           entry;
  logic            entry_valid;

  logic            s1_valid, s2_valid, s3_valid, s4_valid;
  logic            s5_valid, s6_valid, s7_valid;
  logic [CH_W-1:0] s1_ch, s2_ch, s3_ch, s4_ch, s5_ch, s6_ch, s7_ch;

  logic        s1_neg;
  logic [27:0] s1_prod;
  logic [15:0] s2_v;
  logic [15:0] s3_v;
  logic [6:0]  s3_q0;
  logic [6:0]  s4_thou, s5_thou, s6_thou, s7_thou;
  logic [9:0]  s4_rem, s5_rem;
  logic [3:0]  s5_hund, s6_hund, s7_hund;
  logic [6:0]  s6_r2, s7_r2;
  logic [3:0]  s7_tens;

  sample_t     smp;
  logic [15:0] mag;
  logic [28:0] prod_full;
  logic [12:0] quo_a;
  logic [15:0] quo_r;
  logic [12:0] quo;
  logic [30:0] recip_prod;
  logic [16:0] m1000;
  logic [16:0] r_diff;
  logic [10:0] r_thou;
  logic [15:0] hp;
  logic [10:0] m100;
  logic [10:0] r2_diff;
  logic [14:0] tp;
  logic [7:0]  m10;
  logic [3:0]  units;

  assign in_ready   = !busy;
  assign push_valid = entry_valid;
  assign push_data  = entry;

  always_comb begin
    smp       = frame[issue_idx];
    mag       = smp[15] ? (~smp + 16'd1) : smp;
    prod_full = {13'd0, mag} * {16'd0, SCALE_MUL};
    quo_a     = s1_prod[27:15];
    quo_r     = {1'b0, s1_prod[14:0]} + {3'd0, quo_a};
    quo       = quo_a + {12'd0, (quo_r >= SCALE_DIV)};
    recip_prod = {15'd0, s2_v} * {16'd0, RECIP_1000};
    m1000     = {10'd0, s3_q0} * {7'd0, K_1000};
    r_diff    = {1'b0, s3_v} - m1000;
    r_thou    = r_diff[10:0];
    hp        = {6'd0, s4_rem} * {10'd0, RECIP_100};
    m100      = {7'd0, s5_hund} * {4'd0, K_100};
    r2_diff   = {1'b0, s5_rem} - m100;
    tp        = {8'd0, s6_r2} * {7'd0, RECIP_10};
    m10       = {4'd0, s7_tens} * {4'd0, K_10};
    units     = s7_r2[3:0] - m10[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      issuing     <= 1'b0;
      issue_idx   <= '0;
      entry_valid <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      s5_valid    <= 1'b0;
      s6_valid    <= 1'b0;
      s7_valid    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy      <= 1'b1;
        issuing   <= 1'b1;
        issue_idx <= '0;
      end else if (issuing) begin
        if (issue_idx == LAST_CH) begin
          issuing <= 1'b0;
        end
        issue_idx <= issue_idx + 1'b1;
      end
      s1_valid <= issuing;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      if (s7_valid && s7_ch == LAST_CH) begin
        entry_valid <= 1'b1;
      end else if (entry_valid && push_ready) begin
        entry_valid <= 1'b0;
        busy        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= frame_in;
    end
    s1_ch   <= issue_idx;
    s1_neg  <= smp[15];
    s1_prod <= prod_full[27:0];

    s2_ch <= s1_ch;
    s2_v  <= s1_neg ? (OFFSET - {3'd0, quo}) : (OFFSET + {3'd0, quo});

    s3_ch <= s2_ch;
    s3_v  <= s2_v;
    s3_q0 <= recip_prod[30:24];

    s4_ch <= s3_ch;
    if (r_thou >= {1'b0, K_1000}) begin
      s4_thou <= s3_q0 + 7'd1;
      s4_rem  <= 10'(r_thou - {1'b0, K_1000});
    end else begin
      s4_thou <= s3_q0;
      s4_rem  <= r_thou[9:0];
    end

    s5_ch   <= s4_ch;
    s5_thou <= s4_thou;
    s5_rem  <= s4_rem;
    s5_hund <= hp[15:12];

    s6_ch   <= s5_ch;
    s6_thou <= s5_thou;
    s6_hund <= s5_hund;
    s6_r2   <= r2_diff[6:0];

    s7_ch   <= s6_ch;
    s7_thou <= s6_thou;
    s7_hund <= s6_hund;
    s7_r2   <= s6_r2;
    s7_tens <= tp[14:11];

    if (s7_valid) begin
      entry[s7_ch].thou  <= s7_thou;
      entry[s7_ch].hund  <= s7_hund;
      entry[s7_ch].tens  <= s7_tens;
      entry[s7_ch].units <= units;
    end
  end

endmodule

`default_nettype wire

// File: rtl/afdt_queue.sv
// Two-entry queue of converted lines between the front and back parts.
// Uses afdt_pkg for the line type.
`timescale 1ns / 1ps
`default_nettype none

module afdt_queue import afdt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire line_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output line_t      pop_data
);

  line_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/afdt_back.sv
// Back part: walks the queued line and sends it out one ASCII byte per cycle
// while out_ready allows. Holds the byte in an output register. Uses afdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afdt_back import afdt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire line_t pop_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] text_byte,
  output logic       line_end
);

  logic [CH_W-1:0] ch_idx;
  logic [2:0]      sub;
  logic            load;
  logic            last;
  chan_t           cur;
  logic [7:0]      byte_next;

  assign load      = pop_valid && (!out_valid || out_ready);
  assign last      = (sub == SUB_LF);
  assign pop_ready = load && last;
  assign cur       = pop_data[ch_idx];

  always_comb begin
    case (sub)
      SUB_THOU:  byte_next = ASCII_ZERO + {1'b0, cur.thou};
      SUB_HUND:  byte_next = ASCII_ZERO + {4'd0, cur.hund};
      SUB_TENS:  byte_next = ASCII_ZERO + {4'd0, cur.tens};
      SUB_UNITS: byte_next = ASCII_ZERO + {4'd0, cur.units};
      SUB_SEP:   byte_next = (ch_idx == LAST_CH) ? ASCII_CR : ASCII_SPACE;
      default:   byte_next = ASCII_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch_idx    <= '0;
      sub       <= SUB_THOU;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (last) begin
          ch_idx <= '0;
          sub    <= SUB_THOU;
        end else if (sub == SUB_SEP && ch_idx != LAST_CH) begin
          ch_idx <= ch_idx + 1'b1;
          sub    <= SUB_THOU;
        end else begin
          sub <= sub + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_byte <= byte_next;
      line_end  <= last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/adc_frame_to_decimal_text_unit.sv
// Top level of the ADC frame to decimal text formatter.
// Instantiates afdt_front, afdt_queue and afdt_back; uses afdt_pkg.
//
// Each accepted frame of eight signed samples becomes one 41-byte text line:
// per channel four decimal bytes of (sample*5560/32767 + 3276) mod 65536, the
// first being '0' plus the thousands count (above '9' for values of 10000 and
// up), channels split by spaces, ending in CR LF with line_end set on the LF.
// The output runs at one byte per cycle while out_ready is high, and the byte
// serializer sets the rate at which frames stream back to back. The front
// converts a frame and a two-line queue lets it run ahead of the serializer.
`timescale 1ns / 1ps
`default_nettype none

module adc_frame_to_decimal_text_unit import afdt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] sample_0,
  input  wire logic signed [15:0] sample_1,
  input  wire logic signed [15:0] sample_2,
  input  wire logic signed [15:0] sample_3,
  input  wire logic signed [15:0] sample_4,
  input  wire logic signed [15:0] sample_5,
  input  wire logic signed [15:0] sample_6,
  input  wire logic signed [15:0] sample_7,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       text_byte,
  output logic             line_end
);

  frame_t frame_in;
  logic   push_valid;
  logic   push_ready;
  line_t  push_data;
  logic   pop_valid;
  logic   pop_ready;
  line_t  pop_data;

  assign frame_in[0] = sample_0;
  assign frame_in[1] = sample_1;
  assign frame_in[2] = sample_2;
  assign frame_in[3] = sample_3;
  assign frame_in[4] = sample_4;
  assign frame_in[5] = sample_5;
  assign frame_in[6] = sample_6;
  assign frame_in[7] = sample_7;

  afdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_in   (frame_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  afdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  afdt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_byte (text_byte),
    .line_end  (line_end)
  );

endmodule

`default_nettype wire
